/* rtl/pim_pkg.sv */
`timescale 1ns / 1ps

package pim_pkg;

  localparam int COLOR_W         = 24;
  localparam int ENTRY_W         = 8;
  localparam int COUNT_W         = 7;
  localparam int KIND_W          = 2;
  localparam int APB_ADDR_W      = 3;

  localparam int PALETTE_ENTRIES = 256;
  localparam int UNKNOWN_SLOTS   = 100;

  // Each cell of either chain holds this many colours side by side.
  localparam int CELL_SLOTS      = 16;
  localparam int SLOT_W          = $clog2(CELL_SLOTS);
  localparam int PAL_CELLS       = (PALETTE_ENTRIES + CELL_SLOTS - 1) / CELL_SLOTS;
  localparam int UNK_CELLS       = (UNKNOWN_SLOTS + CELL_SLOTS - 1) / CELL_SLOTS;
  localparam int PAL_CELL_W      = (PAL_CELLS > 1) ? $clog2(PAL_CELLS) : 1;
  localparam int UNK_CELL_W      = (UNK_CELLS > 1) ? $clog2(UNK_CELLS) : 1;
  localparam int CELL_W          = (PAL_CELL_W > UNK_CELL_W) ? PAL_CELL_W : UNK_CELL_W;
  localparam int TOK_IDX_W       = CELL_W + SLOT_W;
  localparam int LIM_W           = TOK_IDX_W + 1;
  localparam int UNK_CNT_W       = $clog2(UNKNOWN_SLOTS + 1);

  localparam logic FILL_IDX_REG  = 1'b0;

  typedef enum logic [KIND_W-1:0] {
    KIND_WRITE = 2'd0,
    KIND_PIXEL = 2'd1,
    KIND_START = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PAL,
    ST_UNK,
    ST_RESULT
  } state_e;

  typedef struct packed {
    logic                 valid;
    logic [COLOR_W-1:0]   color;
    logic                 hit;
    logic [TOK_IDX_W-1:0] idx;
  } tok_t;

  typedef struct packed {
    logic                 en;
    logic [TOK_IDX_W-1:0] idx;
    logic [COLOR_W-1:0]   color;
  } wr_t;

endpackage

/* rtl/pim_cell.sv */
`timescale 1ns / 1ps

module pim_cell import pim_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [CELL_W-1:0] cell_num_i,
  input  logic [LIM_W-1:0]  limit_i,
  input  wr_t               wr_i,
  input  tok_t              tok_i,
  output tok_t              tok_o
);

  logic [COLOR_W-1:0]    ent_q [CELL_SLOTS];
  logic [CELL_SLOTS-1:0] hit_vec;
  logic                  found;
  logic [SLOT_W-1:0]     found_off;
  tok_t                  tok_d;
  tok_t                  tok_q;

  always_comb begin
    for (int i = 0; i < CELL_SLOTS; i++) begin
      hit_vec[i] = (LIM_W'({cell_num_i, SLOT_W'(i)}) < limit_i) && (ent_q[i] == tok_i.color);
    end
  end

  always_comb begin
    found     = 1'b0;
    found_off = '0;
    for (int i = CELL_SLOTS - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        found     = 1'b1;
        found_off = SLOT_W'(i);
      end
    end
  end

  always_comb begin
    tok_d = tok_i;
    if (tok_i.valid && !tok_i.hit && found) begin
      tok_d.hit = 1'b1;
      tok_d.idx = {cell_num_i, found_off};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CELL_SLOTS; i++) begin
        ent_q[i] <= '0;
      end
    end else if (wr_i.en && (wr_i.idx[TOK_IDX_W-1:SLOT_W] == cell_num_i)) begin
      ent_q[wr_i.idx[SLOT_W-1:0]] <= wr_i.color;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

/* rtl/rgb_to_palette_index_matcher_core.sv */
`timescale 1ns / 1ps
// Channel   Direction  Word
// s_axis    in         tuser: kind; tdata: entry_index, red, green, blue
// m_axis    out        tdata: palette_index, matched, new_unknown, unknown_count
// apb       in/out     fill_index at byte address 0
//
// A pixel passes the palette chain one cell per cycle, then the result and output
// registers; when the colour is missing and the list not full, it passes the unknown-colour
// chain before the result register. Palette writes, start words and unused kinds leave
// the sequencer idle. One word is worked on at a time; the output register lets the next
// word in while a result waits. Reset clears the palette, the unknown count and fill_index.

module rgb_to_palette_index_matcher_core import pim_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [31:0]           s_axis_tdata,  // entry_index, red, green, blue
  input  logic [KIND_W-1:0]     s_axis_tuser,  // kind
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [23:0]           m_axis_tdata,  // palette_index, matched, new_unknown,
                                               // unknown_count, zero padding
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  state_e                 state_q, state_d;
  logic [ENTRY_W-1:0]     fill_q;
  logic [UNK_CNT_W-1:0]   total_q, total_d;
  logic [ENTRY_W-1:0]     res_idx_q;
  logic                   res_matched_q;
  logic                   res_new_q;
  logic                   out_valid_q, out_valid_d;
  logic [ENTRY_W-1:0]     out_idx_q;
  logic                   out_matched_q;
  logic                   out_new_q;
  logic [COUNT_W-1:0]     out_count_q;
  logic                   accept;
  logic                   load;
  logic                   full;
  logic                   unk_add;
  logic [ENTRY_W-1:0]     in_entry;
  logic [COLOR_W-1:0]     in_color;
  tok_t                   pal_tok [PAL_CELLS+1];
  tok_t                   unk_tok [UNK_CELLS+1];
  wr_t                    pal_wr;
  wr_t                    unk_wr;
  logic [PAL_CELLS-1:0]   pal_valid;

  assign in_entry = s_axis_tdata[7:0];
  assign in_color = {s_axis_tdata[15:8], s_axis_tdata[23:16], s_axis_tdata[31:24]};
  assign accept   = s_axis_tvalid && s_axis_tready;
  assign full     = (total_q == UNK_CNT_W'(UNKNOWN_SLOTS));
  assign unk_add  = unk_tok[UNK_CELLS].valid && !unk_tok[UNK_CELLS].hit;

  // Configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == FILL_IDX_REG) ? {24'd0, fill_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else if (psel && penable && pwrite && pready && (paddr[2] == FILL_IDX_REG)) begin
      fill_q <= pwdata[ENTRY_W-1:0];
    end
  end

  // Palette chain
  always_comb begin
    pal_wr.en    = accept && (s_axis_tuser == KIND_WRITE) &&
                   ({1'b0, in_entry} < 9'(PALETTE_ENTRIES));
    pal_wr.idx   = TOK_IDX_W'(in_entry);
    pal_wr.color = in_color;
    pal_tok[0].valid = accept && (s_axis_tuser == KIND_PIXEL);
    pal_tok[0].color = in_color;
    pal_tok[0].hit   = 1'b0;
    pal_tok[0].idx   = '0;
  end

  for (genvar k = 0; k < PAL_CELLS; k++) begin : g_pal
    pim_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_num_i (CELL_W'(k)),
      .limit_i    (LIM_W'(PALETTE_ENTRIES)),
      .wr_i       (pal_wr),
      .tok_i      (pal_tok[k]),
      .tok_o      (pal_tok[k+1])
    );
    assign pal_valid[k] = pal_tok[k+1].valid;
  end

  // Unknown-colour chain
  always_comb begin
    unk_wr.en    = unk_add;
    unk_wr.idx   = TOK_IDX_W'(total_q);
    unk_wr.color = unk_tok[UNK_CELLS].color;
    unk_tok[0].valid = pal_tok[PAL_CELLS].valid && !pal_tok[PAL_CELLS].hit && !full;
    unk_tok[0].color = pal_tok[PAL_CELLS].color;
    unk_tok[0].hit   = 1'b0;
    unk_tok[0].idx   = '0;
  end

  for (genvar k = 0; k < UNK_CELLS; k++) begin : g_unk
    pim_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_num_i (CELL_W'(k)),
      .limit_i    (LIM_W'(total_q)),
      .wr_i       (unk_wr),
      .tok_i      (unk_tok[k]),
      .tok_o      (unk_tok[k+1])
    );
  end

  always_comb begin
    total_d = total_q;
    if (accept && (s_axis_tuser == KIND_START)) begin
      total_d = '0;
    end else if (unk_add) begin
      total_d = total_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
    end else begin
      total_q <= total_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pal_tok[PAL_CELLS].valid) begin
      res_idx_q     <= pal_tok[PAL_CELLS].hit ? ENTRY_W'(pal_tok[PAL_CELLS].idx) : fill_q;
      res_matched_q <= pal_tok[PAL_CELLS].hit;
      res_new_q     <= 1'b0;
    end else if (unk_add) begin
      res_new_q     <= 1'b1;
    end
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && (s_axis_tuser == KIND_PIXEL)) begin
          state_d = ST_PAL;
        end
      end
      ST_PAL: begin
        if (pal_tok[PAL_CELLS].valid) begin
          state_d = (pal_tok[PAL_CELLS].hit || full) ? ST_RESULT : ST_UNK;
        end
      end
      ST_UNK: begin
        if (unk_tok[UNK_CELLS].valid) begin
          state_d = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = (state_q == ST_IDLE);
    load          = (state_q == ST_RESULT) && (!out_valid_q || m_axis_tready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_idx_q     <= res_idx_q;
      out_matched_q <= res_matched_q;
      out_new_q     <= res_new_q;
      out_count_q   <= COUNT_W'(total_q);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, out_count_q, out_new_q, out_matched_q, out_idx_q};

  // Checks
  a_one_pixel_in_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(pal_valid))
    else $error("more than one pixel in the palette chain");

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= UNK_CNT_W'(UNKNOWN_SLOTS))
    else $error("unknown count above list size");

  a_hit_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pal_tok[PAL_CELLS].valid && pal_tok[PAL_CELLS].hit) |->
      (LIM_W'(pal_tok[PAL_CELLS].idx) < LIM_W'(PALETTE_ENTRIES)))
    else $error("palette hit outside the palette");

  a_new_not_matched: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_new_q && out_matched_q))
    else $error("matched word flagged as new unknown colour");

  a_add_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (unk_add && (state_q == ST_UNK)) |=> (total_q == $past(total_q) + 1'b1))
    else $error("recorded colour not counted");

endmodule
